// ===== rtl/qzi_pkg.sv =====
// Package for the hierarchical Z-order index block: widths, limits,
// register indexes and the command/status structs between controller and datapath.
// No dependencies.
package qzi_pkg;

   localparam int MAX_SIDE_VAL   = 1024;
   localparam int MAX_LEVELS_VAL = 16;

   localparam int SIDE_W  = $clog2(MAX_SIDE_VAL) + 1;   // grid side, holds MAX_SIDE
   localparam int COORD_W = 10;                         // cell coordinate field
   localparam int IDX_W   = 20;                         // z_index field
   localparam int LVL_W   = 5;                          // num_levels register
   localparam int CNT_W   = $clog2(MAX_LEVELS_VAL);     // split counter, 0..MAX_LEVELS-1

   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = SIDE_W;

   localparam logic [SIDE_W-1:0] MAX_SIDE   = SIDE_W'(MAX_SIDE_VAL);
   localparam logic [LVL_W-1:0]  MAX_LEVELS = LVL_W'(MAX_LEVELS_VAL);

   // register indexes of the configuration port
   localparam logic [CSR_ADDR_W-1:0] CSR_GRID_WIDTH  = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_GRID_HEIGHT = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_NUM_LEVELS  = 2'd2;

   typedef struct packed {
      logic load;    // capture the item and the grid size
      logic split;   // one quadrant level
      logic leaf;    // row-major term of the leaf block
      logic emit;    // write the result register
   } qzi_cmd_type;

   typedef struct packed {
      logic [CNT_W-1:0] splits;    // quadrant rounds for the current config
      logic             out_free;  // result register can take a new item
   } qzi_sts_type;

endpackage

// ===== rtl/qzi_chan_if.sv =====
// Channel interfaces of the Z-order index block: request and response.
// Depends on qzi_pkg.
interface qzi_req_if;
   import qzi_pkg::*;
   logic               valid;
   logic               ready;
   logic [COORD_W-1:0] cell_col;
   logic [COORD_W-1:0] cell_row;

   modport source (output valid, output cell_col, output cell_row, input ready);
   modport sink   (input valid, input cell_col, input cell_row, output ready);
endinterface

interface qzi_rsp_if;
   import qzi_pkg::*;
   logic             valid;
   logic             ready;
   logic [IDX_W-1:0] z_index;
   logic             valid_res;

   modport source (output valid, output z_index, output valid_res, input ready);
   modport sink   (input valid, input z_index, input valid_res, output ready);
endinterface

// ===== rtl/qzi_ctrl.sv =====
// Sequencer of the Z-order index block: steps one item through its levels.
// Depends on qzi_pkg.
module qzi_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  qzi_pkg::qzi_sts_type sts,
   output qzi_pkg::qzi_cmd_type cmd
);
   import qzi_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_SPLIT = 3'b010,
      ST_EMIT  = 3'b100
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               cnt_in   = '0;
               state_in = ST_SPLIT;
            end
         end
         ST_SPLIT: begin
            if (cnt_ff == sts.splits) begin
               cmd.leaf = 1'b1;
               state_in = ST_EMIT;
            end else begin
               cmd.split = 1'b1;
               cnt_in    = cnt_ff + 1'b1;
            end
         end
         ST_EMIT: begin
            // hold until the result register is free
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

// ===== rtl/qzi_dpath.sv =====
// Datapath of the Z-order index block: config registers, quadrant step,
// index accumulator and result register. Depends on qzi_pkg.
module qzi_dpath (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [qzi_pkg::CSR_ADDR_W-1:0]  csr_index,
   input  logic [qzi_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic [qzi_pkg::COORD_W-1:0]     cell_col,
   input  logic [qzi_pkg::COORD_W-1:0]     cell_row,
   input  logic                            rsp_ready,
   output logic                            rsp_valid,
   output logic [qzi_pkg::IDX_W-1:0]       z_index,
   output logic                            valid_res,
   input  qzi_pkg::qzi_cmd_type            cmd,
   output qzi_pkg::qzi_sts_type            sts
);
   import qzi_pkg::*;

   logic [SIDE_W-1:0]  cfg_w_ff, cfg_h_ff;
   logic [LVL_W-1:0]   cfg_lv_ff;
   logic [SIDE_W-1:0]  w_sat, h_sat;

   logic [SIDE_W-1:0]  w_ff, h_ff;
   logic [COORD_W-1:0] x_ff, y_ff;
   logic [IDX_W-1:0]   idx_ff, p_ff;
   logic               inside_ff;
   logic               rsp_valid_ff;
   logic [IDX_W-1:0]   z_ff;
   logic               vres_ff;

   logic [COORD_W-1:0] bh, lw;
   logic               y_lo, x_lo;
   logic [SIDE_W-1:0]  h_n, w_n;
   logic [COORD_W-1:0] y_n, x_n;
   logic [IDX_W:0]     prod_v, prod_h, prod_leaf;
   logic [IDX_W-1:0]   p_split;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_w_ff  <= SIDE_W'(1);
         cfg_h_ff  <= SIDE_W'(1);
         cfg_lv_ff <= LVL_W'(1);
      end else if (csr_we) begin
         case (csr_index)
            CSR_GRID_WIDTH:  cfg_w_ff  <= csr_wdata;
            CSR_GRID_HEIGHT: cfg_h_ff  <= csr_wdata;
            CSR_NUM_LEVELS:  cfg_lv_ff <= csr_wdata[LVL_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign w_sat = (cfg_w_ff > MAX_SIDE) ? MAX_SIDE : cfg_w_ff;
   assign h_sat = (cfg_h_ff > MAX_SIDE) ? MAX_SIDE : cfg_h_ff;

   always_comb begin
      if (cfg_lv_ff <= LVL_W'(1))
         sts.splits = '0;
      else if (cfg_lv_ff > MAX_LEVELS)
         sts.splits = CNT_W'(MAX_LEVELS - 1'b1);
      else
         sts.splits = CNT_W'(cfg_lv_ff - 1'b1);
      sts.out_free = !rsp_valid_ff || rsp_ready;
   end

   // one quadrant level: bottom/top, then left/right within the chosen half
   assign bh   = h_ff[SIDE_W-1:1];
   assign lw   = w_ff[SIDE_W-1:1];
   assign y_lo = y_ff < bh;
   assign h_n  = y_lo ? {1'b0, bh} : (h_ff - {1'b0, bh});
   assign y_n  = y_lo ? y_ff : (y_ff - bh);
   assign x_lo = x_ff < lw;
   assign w_n  = x_lo ? {1'b0, lw} : (w_ff - {1'b0, lw});
   assign x_n  = x_lo ? x_ff : (x_ff - lw);

   assign prod_v    = (IDX_W+1)'(w_ff) * (IDX_W+1)'(bh);
   assign prod_h    = (IDX_W+1)'(lw) * (IDX_W+1)'(h_n);
   assign prod_leaf = (IDX_W+1)'(y_ff) * (IDX_W+1)'(w_ff) + (IDX_W+1)'(x_ff);
   assign p_split   = (y_lo ? '0 : prod_v[IDX_W-1:0]) + (x_lo ? '0 : prod_h[IDX_W-1:0]);

   // products are registered in p_ff and folded into idx_ff one step later
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         w_ff      <= w_sat;
         h_ff      <= h_sat;
         x_ff      <= cell_col;
         y_ff      <= cell_row;
         idx_ff    <= '0;
         p_ff      <= '0;
         inside_ff <= (SIDE_W'(cell_col) < w_sat) && (SIDE_W'(cell_row) < h_sat);
      end else if (cmd.split) begin
         w_ff   <= w_n;
         h_ff   <= h_n;
         x_ff   <= x_n;
         y_ff   <= y_n;
         idx_ff <= idx_ff + p_ff;
         p_ff   <= p_split;
      end else if (cmd.leaf) begin
         idx_ff <= idx_ff + p_ff;
         p_ff   <= prod_leaf[IDX_W-1:0];
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         z_ff    <= inside_ff ? (idx_ff + p_ff) : '0;
         vres_ff <= inside_ff;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign z_index      = z_ff;
   assign valid_res    = vres_ff;

endmodule

// ===== rtl/quadtree_zorder_index.sv =====
// Top level of the hierarchical Z-order index block.
// Depends on qzi_pkg, qzi_chan_if, qzi_ctrl and qzi_dpath.
//
// Maps one cell coordinate (cell_col, cell_row) of a grid_width by grid_height
// grid to its position in a quadrant Z-order of num_levels levels: each level
// splits the current block into lower-left, lower-right, upper-left and
// upper-right quadrants (floor half to the left and bottom parts) and adds the
// cell counts of the quadrants that come before the one holding the cell; the
// leaf block is numbered row-major. A coordinate outside the grid returns
// valid_res low with z_index zero. Sides above 1024 saturate to 1024, a
// num_levels of 0 acts as 1 and one above 16 acts as 16. Each item is accepted,
// then takes a quadrant split step for every level but the last, a leaf step
// and the write into the output register; the quadrant step unit handles one
// level per cycle. The next item is accepted in the cycle after the result is
// written into the output register, even while that result still waits for
// rsp ready; the block takes one item at a time. Configuration registers
// (index 0 grid_width, 1 grid_height, 2 num_levels) are written through
// csr_we/csr_index/csr_wdata and must only change while no item is in flight.
module quadtree_zorder_index (
   input  logic                           clock,
   input  logic                           reset,
   qzi_req_if.sink                        req_if,
   qzi_rsp_if.source                      rsp_if,
   input  logic                           csr_we,
   input  logic [qzi_pkg::CSR_ADDR_W-1:0] csr_index,
   input  logic [qzi_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import qzi_pkg::*;

   qzi_cmd_type cmd;
   qzi_sts_type sts;

   // sequencer: accept, step through the levels, hand off to the result register
   qzi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // datapath: config, quadrant step, accumulator, result register
   qzi_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cell_col  (req_if.cell_col),
      .cell_row  (req_if.cell_row),
      .rsp_ready (rsp_if.ready),
      .rsp_valid (rsp_if.valid),
      .z_index   (rsp_if.z_index),
      .valid_res (rsp_if.valid_res),
      .cmd       (cmd),
      .sts       (sts)
   );

endmodule

// ===== rtl/qzi_checker.sv =====
// Port-level checks of the Z-order index block, bound to its top level.
// Depends on qzi_pkg and quadtree_zorder_index.
module qzi_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [qzi_pkg::IDX_W-1:0]   z_index,
   input logic                        valid_res
);
   import qzi_pkg::*;

   // drop the response after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(z_index) && $stable(valid_res))
      else $error("stalled response changed");

   // outside cells carry a zero index
   a_outside_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !valid_res |-> z_index == '0)
      else $error("outside cell with nonzero index");

   // one item at a time: no acceptance right after one
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request ready right after acceptance");

endmodule

bind quadtree_zorder_index qzi_checker u_qzi_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_if.valid),
   .req_ready (req_if.ready),
   .rsp_valid (rsp_if.valid),
   .rsp_ready (rsp_if.ready),
   .z_index   (rsp_if.z_index),
   .valid_res (rsp_if.valid_res)
);

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// Testbench for quadtree_zorder_index: directed and random cell coordinates over many grid
// settings, each result checked against a built-in Z-order index calculation.
// Depends on qzi_pkg, qzi_chan_if and the RTL of quadtree_zorder_index.
module testbench;
   import qzi_pkg::*;

   localparam int SETTLE_CYCLES  = 24;    // longest item latency plus margin
   localparam int HOLD_CYCLES    = 300;   // long response hold-off that backs up the block
   localparam int PHASE_ITEMS    = 100;
   localparam int RANDOM_PHASES  = 13;

   // Expected result of one cell, with the coordinate kept for the mismatch line.
   typedef struct {
      logic [COORD_W-1:0] col;
      logic [COORD_W-1:0] row;
      logic [IDX_W-1:0]   z_index;
      logic               valid_res;
   } zorder_entry_type;

   // Scoreboard: holds a copy of the grid registers, computes the index of each
   // accepted cell and matches the results in order.
   class zorder_scoreboard;
      logic [SIDE_W-1:0] width_reg;
      logic [SIDE_W-1:0] height_reg;
      logic [LVL_W-1:0]  levels_reg;
      zorder_entry_type  pending_q[$];
      int                errors;
      int                checked;
      int                outside;

      function new();
         width_reg  = 1;
         height_reg = 1;
         levels_reg = 1;
      endfunction

      function void write_reg(logic [CSR_ADDR_W-1:0] index, logic [CSR_DATA_W-1:0] data);
         case (index)
            CSR_GRID_WIDTH: begin
               width_reg = data;
            end
            CSR_GRID_HEIGHT: begin
               height_reg = data;
            end
            CSR_NUM_LEVELS: begin
               levels_reg = data[LVL_W-1:0];
            end
            default: begin
            end
         endcase
      endfunction

      // Walk the quadrant splits: floor halves go left and bottom, and every
      // quadrant passed over adds its cell count; the leaf is row-major.
      function zorder_entry_type zorder_of(logic [COORD_W-1:0] col, logic [COORD_W-1:0] row);
         zorder_entry_type e;
         int unsigned      x, y, w, h, lv, idx, lw, bh, k;
         x  = col;
         y  = row;
         w  = (width_reg > MAX_SIDE_VAL) ? MAX_SIDE_VAL : width_reg;
         h  = (height_reg > MAX_SIDE_VAL) ? MAX_SIDE_VAL : height_reg;
         lv = (levels_reg == 0) ? 1 : levels_reg;
         if (lv > MAX_LEVELS_VAL) lv = MAX_LEVELS_VAL;
         e.col       = col;
         e.row       = row;
         e.z_index   = '0;
         e.valid_res = 1'b0;
         if (x >= w || y >= h) return e;
         idx = 0;
         for (k = 1; k < lv; k++) begin
            lw = w / 2;
            bh = h / 2;
            if (y < bh) begin
               h = bh;
            end else begin
               idx += w * bh;
               y   -= bh;
               h   -= bh;
            end
            if (x < lw) begin
               w = lw;
            end else begin
               idx += lw * h;
               x   -= lw;
               w   -= lw;
            end
         end
         idx += y * w + x;
         e.z_index   = idx[IDX_W-1:0];
         e.valid_res = 1'b1;
         return e;
      endfunction

      function void note_request(logic [COORD_W-1:0] col, logic [COORD_W-1:0] row);
         zorder_entry_type e;
         e = zorder_of(col, row);
         if (!e.valid_res) outside++;
         pending_q.push_back(e);
      endfunction

      task report_mismatch(string msg);
         $display("MISMATCH @%0t: %s", $realtime, msg);
         errors++;
      endtask

      task check_response(logic [IDX_W-1:0] z_index, logic valid_res);
         zorder_entry_type e;
         if (pending_q.size() == 0) begin
            report_mismatch($sformatf("unexpected result z_index=%0d valid_res=%0b",
                                      z_index, valid_res));
            return;
         end
         e = pending_q.pop_front();
         checked++;
         if (valid_res !== e.valid_res)
            report_mismatch($sformatf("cell (%0d,%0d) valid_res=%0b, want %0b",
                                      e.col, e.row, valid_res, e.valid_res));
         if (z_index !== e.z_index)
            report_mismatch($sformatf("cell (%0d,%0d) z_index=%0d, want %0d",
                                      e.col, e.row, z_index, e.z_index));
      endtask
   endclass

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_ADDR_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   qzi_req_if req_ch ();
   qzi_rsp_if rsp_ch ();

   quadtree_zorder_index dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_ch),
      .rsp_if    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   zorder_scoreboard sb = new();

   bit no_idle;       // both sides run without gaps while set
   bit hold_rsp;      // ask the response side for one long hold-off
   int hold_left;
   int n_settings;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Check every result at the rising edge where it is taken.
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
         sb.check_response(rsp_ch.z_index, rsp_ch.valid_res);
   end

   // Response side: drop ready at random, or for a long counted stretch on request.
   initial begin
      rsp_ch.ready = 1'b0;
      hold_left    = 0;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            hold_rsp  = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= no_idle || ($urandom_range(99) >= 11);
         end
      end
   end

   // Hard stop in case the block hangs.
   initial begin
      #5_000_000;
      $display("Timeout with %0d results outstanding", sb.pending_q.size());
      $display("Simulation FAILED");
      $finish;
   end

   // Write one register; the caller lowers csr_we after its last write.
   task automatic write_csr(logic [CSR_ADDR_W-1:0] index, logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      sb.write_reg(index, data);
      @(negedge clock);
   endtask

   // Load a full grid setting; only called while the block is idle.
   task automatic apply_grid(logic [CSR_DATA_W-1:0] w, logic [CSR_DATA_W-1:0] h,
                             logic [LVL_W-1:0] lv);
      write_csr(CSR_GRID_WIDTH, w);
      write_csr(CSR_GRID_HEIGHT, h);
      write_csr(CSR_NUM_LEVELS, CSR_DATA_W'(lv));
      csr_we <= 1'b0;
      n_settings++;
   endtask

   // Offer one cell, with random gaps before it, and hold it until accepted.
   // Valid stays high on return so back-to-back items need no reassertion.
   task automatic send_cell(logic [COORD_W-1:0] col, logic [COORD_W-1:0] row);
      while (!no_idle && $urandom_range(99) < 11) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.cell_col <= col;
      req_ch.cell_row <= row;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      sb.note_request(col, row);
      @(negedge clock);
   endtask

   // Stop offering, wait for every result, then let the block settle.
   task automatic drain();
      req_ch.valid <= 1'b0;
      while (sb.pending_q.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Grid side: mostly ordinary, with zero, one, full and oversized sides mixed in.
   function automatic logic [CSR_DATA_W-1:0] pick_side();
      case ($urandom_range(19))
         0:       return '0;
         1:       return CSR_DATA_W'(1);
         2, 3:    return MAX_SIDE;
         4:       return CSR_DATA_W'($urandom_range(2047, MAX_SIDE_VAL + 1));
         5, 6, 7: return CSR_DATA_W'($urandom_range(8, 1));
         default: return CSR_DATA_W'($urandom_range(MAX_SIDE_VAL, 1));
      endcase
   endfunction

   // Depth: mostly 1..16, with zero, the maximum and oversized values mixed in.
   function automatic logic [LVL_W-1:0] pick_levels();
      case ($urandom_range(15))
         0:       return '0;
         1:       return LVL_W'($urandom_range(31, MAX_LEVELS_VAL + 1));
         2, 3:    return MAX_LEVELS;
         default: return LVL_W'($urandom_range(MAX_LEVELS_VAL, 1));
      endcase
   endfunction

   // Coordinate: nine in ten inside the grid, the rest anywhere in the field.
   function automatic logic [COORD_W-1:0] pick_coord(logic [CSR_DATA_W-1:0] side);
      int unsigned eff;
      eff = (side > MAX_SIDE_VAL) ? MAX_SIDE_VAL : side;
      if (eff > 0 && $urandom_range(9) != 0) return COORD_W'($urandom_range(eff - 1));
      return COORD_W'($urandom_range(1023));
   endfunction

   initial begin
      logic [CSR_DATA_W-1:0] w, h;
      logic [LVL_W-1:0]      lv;

      // Hold every input at a known value from time zero.
      reset           = 1'b1;
      csr_we          = 1'b0;
      csr_index       = CSR_GRID_WIDTH;
      csr_wdata       = '0;
      req_ch.valid    = 1'b0;
      req_ch.cell_col = '0;
      req_ch.cell_row = '0;
      no_idle         = 1'b0;
      hold_rsp        = 1'b0;
      n_settings      = 1;

      repeat (7) @(negedge clock);
      reset <= 1'b0;

      // Reset setting: a single-cell grid; everything but the origin is outside.
      send_cell(0, 0);
      send_cell(1023, 1023);
      send_cell(1, 0);
      send_cell(0, 1);
      drain();

      // Full grid at full depth: corners and the cells around the first split.
      apply_grid(MAX_SIDE, MAX_SIDE, MAX_LEVELS);
      send_cell(0, 0);
      send_cell(1023, 1023);
      send_cell(1023, 0);
      send_cell(0, 1023);
      send_cell(511, 512);
      send_cell(512, 511);
      drain();

      // Zero width with zero levels: no cell lies inside.
      apply_grid(0, 5, 0);
      send_cell(0, 0);
      send_cell(3, 2);
      drain();

      // Oversized width saturates, too many levels saturate.
      apply_grid(2047, 3, 31);
      send_cell(1023, 2);
      send_cell(1023, 3);
      send_cell(0, 0);
      drain();

      // Zero height.
      apply_grid(5, 0, 20);
      send_cell(0, 0);
      drain();

      // One column wide at full depth: splits go on past single-cell quadrants.
      apply_grid(1, MAX_SIDE, MAX_LEVELS);
      send_cell(0, 1023);
      send_cell(0, 500);
      drain();

      // No split at all: the whole grid is row-major.
      apply_grid(1000, 777, 1);
      send_cell(999, 776);
      send_cell(1000, 0);
      drain();

      // Random settings, mostly in-grid coordinates. One phase runs with no gaps,
      // another opens with a long response hold-off so the block backs up.
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         w  = pick_side();
         h  = pick_side();
         lv = pick_levels();
         apply_grid(w, h, lv);
         no_idle = (p == 6);
         if (p == 3) hold_rsp = 1'b1;
         for (int i = 0; i < PHASE_ITEMS; i++)
            send_cell(pick_coord(w), pick_coord(h));
         drain();
         no_idle = 1'b0;
      end

      $display("Checked %0d results over %0d grid settings, %0d cells outside the grid.",
               sb.checked, n_settings, sb.outside);
      if (sb.errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("%0d mismatches", sb.errors);
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
